[hdl/hkr_pkg.sv]
// hkr_pkg: shared types and codes for the hash keyed registry table
`timescale 1ns / 1ps

package hkr_pkg;

  localparam int unsigned KEY_W  = 256;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned SIZE_W = 8;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned FILL_W = 7;

  // command codes; code 3 decodes as a clear
  localparam logic [CMD_W-1:0] CMD_ADD     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESOLVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

  typedef enum logic [2:0] {
    STAT_ADDED     = 3'd0,
    STAT_DUPLICATE = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_FOUND     = 3'd3,
    STAT_NOT_FOUND = 3'd4,
    STAT_CLEARED   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_SEARCH,
    ENG_DONE
  } eng_state_t;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot_index;
    logic [KEY_W-1:0]    root;
    logic [FILL_W-1:0]   fill_count;
  } result_t;

endpackage

[hdl/hkr_if.sv]
// hkr_if: valid/ready channel interfaces for command items and result items
`timescale 1ns / 1ps

interface hkr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [63:0] key_word0;
  logic [63:0] key_word1;
  logic [63:0] key_word2;
  logic [63:0] key_word3;
  logic [7:0]  size_low_byte;

  modport source (
    output valid, command, key_word0, key_word1, key_word2, key_word3, size_low_byte,
    input  ready
  );
  modport sink (
    input  valid, command, key_word0, key_word1, key_word2, key_word3, size_low_byte,
    output ready
  );
endinterface

interface hkr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [5:0]  slot_index;
  logic [63:0] root_word0;
  logic [63:0] root_word1;
  logic [63:0] root_word2;
  logic [63:0] root_word3;
  logic [6:0]  fill_count;

  modport source (
    output valid, status, slot_index, root_word0, root_word1, root_word2, root_word3,
           fill_count,
    input  ready
  );
  modport sink (
    input  valid, status, slot_index, root_word0, root_word1, root_word2, root_word3,
           fill_count,
    output ready
  );
endinterface

[hdl/hkr_key_mem.sv]
// hkr_key_mem: key store, one 256-bit key per row, one write and one registered read port
`timescale 1ns / 1ps

module hkr_key_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned DW    = 256
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/hkr_engine.sv]
// hkr_engine: command sequencer, linear key search, entry count and root digest
`timescale 1ns / 1ps

module hkr_engine #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned IDX_W    = 6,
  parameter int unsigned CNT_W    = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  hkr_in_if.sink                in_chan,
  output logic                  mem_wr_en,
  output logic [IDX_W-1:0]      mem_wr_addr,
  output logic [hkr_pkg::KEY_W-1:0] mem_wr_data,
  output logic [IDX_W-1:0]      mem_rd_addr,
  input  logic [hkr_pkg::KEY_W-1:0] mem_rd_data,
  output hkr_pkg::result_t      res,
  output logic                  res_valid,
  input  logic                  res_ready
);
  import hkr_pkg::*;

  eng_state_t          state_r, state_nxt;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [SIZE_W-1:0]   size_r, size_nxt;
  logic [IDX_W-1:0]    chk_r, chk_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [KEY_W-1:0]    root_r, root_nxt;
  result_t             res_r, res_nxt;

  logic is_add, is_resolve, is_clear, full, empty, last, hit;
  logic [KEY_W-1:0] root_add;

  assign is_add     = (cmd_r == CMD_ADD);
  assign is_resolve = (cmd_r == CMD_RESOLVE);
  assign is_clear   = !is_add && !is_resolve;
  assign full       = (count_r == CNT_W'(CAPACITY));
  assign empty      = (count_r == '0);
  assign last       = ((CNT_W'(chk_r) + CNT_W'(1)) == count_r);
  assign hit        = (mem_rd_data == key_r);
  // size byte spread over every byte lane of the key
  assign root_add   = root_r ^ key_r ^ {(KEY_W / SIZE_W){size_r}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ENG_IDLE;
      count_r <= '0;
      root_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      root_r  <= root_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    key_r  <= key_nxt;
    size_r <= size_nxt;
    chk_r  <= chk_nxt;
    res_r  <= res_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    key_nxt     = key_r;
    size_nxt    = size_r;
    chk_nxt     = chk_r;
    count_nxt   = count_r;
    root_nxt    = root_r;
    res_nxt     = res_r;
    in_chan.ready = 1'b0;
    res_valid   = 1'b0;
    mem_rd_addr = '0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = count_r[IDX_W-1:0];
    mem_wr_data = key_r;

    case (state_r)
      ENG_IDLE: begin
        in_chan.ready = 1'b1;
        mem_rd_addr   = '0;
        if (in_chan.valid) begin
          cmd_nxt   = in_chan.command;
          key_nxt   = {in_chan.key_word3, in_chan.key_word2,
                       in_chan.key_word1, in_chan.key_word0};
          size_nxt  = in_chan.size_low_byte;
          chk_nxt   = '0;
          state_nxt = ENG_SEARCH;
        end
      end

      ENG_SEARCH: begin
        // prefetch the next entry while the current one is compared
        mem_rd_addr = chk_r + IDX_W'(1);
        res_nxt.slot_index = '0;
        res_nxt.root       = root_r;
        res_nxt.fill_count = FILL_W'(count_r);
        if (is_clear) begin
          count_nxt          = '0;
          root_nxt           = '0;
          res_nxt.status     = STAT_CLEARED;
          res_nxt.root       = '0;
          res_nxt.fill_count = '0;
          state_nxt          = ENG_DONE;
        end else if (is_add && full) begin
          res_nxt.status = STAT_FULL;
          state_nxt      = ENG_DONE;
        end else if (!empty && hit) begin
          if (is_add) begin
            res_nxt.status = STAT_DUPLICATE;
          end else begin
            res_nxt.status     = STAT_FOUND;
            res_nxt.slot_index = SLOT_W'(chk_r);
          end
          state_nxt = ENG_DONE;
        end else if (empty || last) begin
          if (is_add) begin
            mem_wr_en          = 1'b1;
            count_nxt          = count_r + CNT_W'(1);
            root_nxt           = root_add;
            res_nxt.status     = STAT_ADDED;
            res_nxt.slot_index = SLOT_W'(count_r);
            res_nxt.root       = root_add;
            res_nxt.fill_count = FILL_W'(count_r + CNT_W'(1));
          end else begin
            res_nxt.status = STAT_NOT_FOUND;
          end
          state_nxt = ENG_DONE;
        end else begin
          chk_nxt = chk_r + IDX_W'(1);
        end
      end

      ENG_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ENG_IDLE;
        end
      end

      default: begin
        state_nxt = ENG_IDLE;
      end
    endcase
  end

  assign res = res_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> (count_r < CNT_W'(CAPACITY)) && is_add)
    else $error("key written with no room or for a non-add item");

  a_write_count: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("entry count did not follow a key write");

  a_accept_search: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> state_r == ENG_SEARCH)
    else $error("accepted item did not start a search");

  a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ENG_SEARCH && !empty) |-> CNT_W'(chk_r) < count_r)
    else $error("search index past the held entries");
`endif

endmodule

[hdl/hash_keyed_registry_table.sv]
// hash_keyed_registry_table: top level, key store, engine and result register
//
// Usage: one input channel carries command items (add key, resolve key, clear
// table) with a 256-bit key in four words and a size byte; one output channel
// returns one result item per command: status, slot index, the 256-bit root
// digest after the item and the fill count. Both are valid/ready channels; an
// item moves on an edge where valid and ready are both high.
// Timing: an item is accepted only while the engine is idle. Add and resolve
// compare one stored key per cycle through the single read port of the key
// store, up to CAPACITY entries for a miss over a full table (64 with 64
// entries). Clear, an add to a full table and a search of an empty table
// compare no entries. The next item is accepted only after the result has
// passed to the output register. A successful add writes its key in the cycle
// of the final compare.
// Reset: the fill count and the root digest go to zero; the key store is not
// cleared and only compared below the fill count, so no clearing pass runs.
// Stall: a finished result waits in the output register; the next item is
// still accepted and searched, and its result waits until the register frees.
`timescale 1ns / 1ps

module hash_keyed_registry_table #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  hkr_in_if.sink     in_chan,
  hkr_out_if.source  out_chan
);
  import hkr_pkg::*;

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic               mem_wr_en;
  logic [IDX_W-1:0]   mem_wr_addr;
  logic [KEY_W-1:0]   mem_wr_data;
  logic [IDX_W-1:0]   mem_rd_addr;
  logic [KEY_W-1:0]   mem_rd_data;
  result_t            res;
  logic               res_valid;
  logic               res_ready;

  logic               out_valid_r, out_valid_nxt;
  result_t            out_r, out_nxt;

  hkr_key_mem #(
    .DEPTH (CAPACITY),
    .AW    (IDX_W),
    .DW    (KEY_W)
  ) u_key_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  hkr_engine #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .res         (res),
    .res_valid   (res_valid),
    .res_ready   (res_ready)
  );

  // result register frees when empty or when its item leaves this cycle
  assign res_ready = !out_valid_r || out_chan.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = out_r.status;
  assign out_chan.slot_index = out_r.slot_index;
  assign out_chan.root_word0 = out_r.root[WORD_W-1:0];
  assign out_chan.root_word1 = out_r.root[2*WORD_W-1:WORD_W];
  assign out_chan.root_word2 = out_r.root[3*WORD_W-1:2*WORD_W];
  assign out_chan.root_word3 = out_r.root[4*WORD_W-1:3*WORD_W];
  assign out_chan.fill_count = out_r.fill_count;

endmodule
